>>> rtl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared constants, control word layout and the microprogram table for the
// xtea block cipher sequencer.
// ----------------------------------------------------------------------------
package xtea_pkg;

    localparam int WORD_W          = 32;
    localparam int KEY_WORDS       = 4;
    localparam int KEY_IDX_W       = 2;
    localparam int CYCLE_COUNT_DEF = 32;
    localparam int UPC_W           = 3;

    localparam logic [WORD_W-1:0] XT_DELTA = 32'h9e3779b9;

    // sequencing condition of a control word
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ACCEPT,
        COND_LOOP,
        COND_OUT_FREE,
        COND_JUMP
    } cond_t;

    typedef struct packed {
        logic             half_rnd;   // run the half-round unit
        logic             upd_v1;     // update v1 (key by sum[12:11]) else v0 (key by sum[1:0])
        logic             decrypt;    // subtract instead of add
        logic             sum_step;   // step sum by delta
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    // microprogram addresses
    localparam logic [UPC_W-1:0] UA_IDLE    = 3'd0;
    localparam logic [UPC_W-1:0] UA_ENC_A   = 3'd1;
    localparam logic [UPC_W-1:0] UA_ENC_B   = 3'd2;
    localparam logic [UPC_W-1:0] UA_ENC_OUT = 3'd3;
    localparam logic [UPC_W-1:0] UA_DEC_B   = 3'd4;
    localparam logic [UPC_W-1:0] UA_DEC_A   = 3'd5;
    localparam logic [UPC_W-1:0] UA_DEC_OUT = 3'd6;

    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        w        = '0;
        w.cond   = COND_JUMP;
        w.target = UA_IDLE;
        case (addr)
            UA_IDLE: begin
                w.cond = COND_ACCEPT;
            end
            UA_ENC_A: begin
                w.half_rnd = 1'b1;
                w.sum_step = 1'b1;
                w.cond     = COND_NEXT;
            end
            UA_ENC_B: begin
                w.half_rnd = 1'b1;
                w.upd_v1   = 1'b1;
                w.cond     = COND_LOOP;
                w.target   = UA_ENC_A;
            end
            UA_ENC_OUT: begin
                w.cond   = COND_OUT_FREE;
                w.target = UA_IDLE;
            end
            UA_DEC_B: begin
                w.half_rnd = 1'b1;
                w.upd_v1   = 1'b1;
                w.decrypt  = 1'b1;
                w.sum_step = 1'b1;
                w.cond     = COND_NEXT;
            end
            UA_DEC_A: begin
                w.half_rnd = 1'b1;
                w.decrypt  = 1'b1;
                w.cond     = COND_LOOP;
                w.target   = UA_DEC_B;
            end
            UA_DEC_OUT: begin
                w.cond   = COND_OUT_FREE;
                w.target = UA_IDLE;
            end
            default: begin
                w.cond   = COND_JUMP;
                w.target = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/xtea_block_cipher_top.sv
// ----------------------------------------------------------------------------
// xtea_block_cipher_top
// XTEA encrypt/decrypt of one 64-bit block under a 128-bit key, run by a
// microcoded sequencer over a single shared half-round unit.
// ----------------------------------------------------------------------------
// a block is loaded on the wait step, then the one half-round unit does two
//   half-rounds per feistel cycle, then the output step moves it to the output
//   register once that is free; no new block is taken until the wait step is back
// a finished block waits in the output register while the next one is loaded
// reset: synchronous active-low aresetn clears the sequencer, output valid and key
//   words; the block is ready for input in the first cycle after reset
// ----------------------------------------------------------------------------
module xtea_block_cipher_top
    import xtea_pkg::*;
#(
    parameter int CYCLE_COUNT = CYCLE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // key configuration
    input  logic                 cfg_we,
    input  logic [KEY_IDX_W-1:0] cfg_addr,
    input  logic [WORD_W-1:0]    cfg_wdata,

    // input block
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*WORD_W-1:0]  s_tdata,   // [31:0] block_first, [63:32] block_second
    input  logic                 s_tuser,   // [0] opcode (0 encrypt, 1 decrypt)

    // result block
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*WORD_W-1:0]  m_tdata    // [31:0] out_first, [63:32] out_second
);

    localparam int CNT_W = (CYCLE_COUNT > 1) ? $clog2(CYCLE_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CYCLE_COUNT - 1);
    // starting sum for decryption: delta * cycle count, mod 2^32
    localparam logic [2*WORD_W-1:0] DEC_SUM_FULL = 64'(XT_DELTA) * 64'(CYCLE_COUNT);
    localparam logic [WORD_W-1:0]   DEC_SUM0     = DEC_SUM_FULL[WORD_W-1:0];

    // sequencer
    logic [UPC_W-1:0] upc_reg, upc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    uword_t           uw;

    // datapath
    logic [WORD_W-1:0] v0_reg, v0_next;
    logic [WORD_W-1:0] v1_reg, v1_next;
    logic [WORD_W-1:0] sum_reg, sum_next;
    logic [WORD_W-1:0] key_reg [KEY_WORDS];

    // output stage
    logic                m_tvalid_reg, m_tvalid_next;
    logic [2*WORD_W-1:0] out_data_reg, out_data_next;

    // half-round unit
    logic [WORD_W-1:0]    hr_src, hr_dst, hr_mix, hr_rkey, hr_f, hr_res;
    logic [KEY_IDX_W-1:0] hr_kidx;

    logic out_free;

    // the current control word comes straight out of the program table
    assign uw = ucode_rom(upc_reg);

    // input is taken only while parked on the wait step
    assign s_tready = (uw.cond == COND_ACCEPT);
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    // one half-round: dst +/-= mix(other) ^ (sum + key[idx])
    always_comb begin
        hr_src  = uw.upd_v1 ? v0_reg : v1_reg;
        hr_dst  = uw.upd_v1 ? v1_reg : v0_reg;
        hr_kidx = uw.upd_v1 ? sum_reg[12:11] : sum_reg[1:0];
        hr_mix  = ((hr_src << 4) ^ (hr_src >> 5)) + hr_src;
        hr_rkey = sum_reg + key_reg[hr_kidx];
        hr_f    = hr_mix ^ hr_rkey;
        hr_res  = uw.decrypt ? (hr_dst - hr_f) : (hr_dst + hr_f);
    end

    // step counter and program counter
    always_comb begin
        upc_next = upc_reg;
        cnt_next = cnt_reg;
        case (uw.cond)
            COND_ACCEPT: begin
                if (s_tvalid) begin
                    cnt_next = '0;
                    upc_next = s_tuser ? UA_DEC_B : UA_ENC_A;
                end
            end
            COND_NEXT: begin
                upc_next = upc_reg + UPC_W'(1);
            end
            COND_LOOP: begin
                // fall through to the output step after the last cycle
                if (cnt_reg == CNT_LAST) begin
                    upc_next = upc_reg + UPC_W'(1);
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    upc_next = uw.target;
                end
            end
            COND_OUT_FREE: begin
                if (out_free) begin
                    upc_next = uw.target;
                end
            end
            COND_JUMP: begin
                upc_next = uw.target;
            end
            default: begin
                upc_next = UA_IDLE;
            end
        endcase
    end

    // block words and running sum
    always_comb begin
        v0_next  = v0_reg;
        v1_next  = v1_reg;
        sum_next = sum_reg;
        if (uw.cond == COND_ACCEPT && s_tvalid) begin
            v0_next  = s_tdata[WORD_W-1:0];
            v1_next  = s_tdata[2*WORD_W-1:WORD_W];
            sum_next = s_tuser ? DEC_SUM0 : '0;
        end
        if (uw.half_rnd) begin
            if (uw.upd_v1) begin
                v1_next = hr_res;
            end else begin
                v0_next = hr_res;
            end
        end
        if (uw.sum_step) begin
            sum_next = uw.decrypt ? (sum_reg - XT_DELTA) : (sum_reg + XT_DELTA);
        end
    end

    // output register: loaded on the output step when free
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        out_data_next = out_data_reg;
        if (uw.cond == COND_OUT_FREE && out_free) begin
            m_tvalid_next = 1'b1;
            out_data_next = {v1_reg, v0_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg      <= UA_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            upc_reg      <= upc_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v0_reg       <= v0_next;
        v1_reg       <= v1_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    // key words, written any time, cleared by reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            key_reg[cfg_addr] <= cfg_wdata;
        end
    end

endmodule

>>> rtl/xtea_chk.sv
// ----------------------------------------------------------------------------
// xtea_chk
// Port-level checks on the xtea block cipher, bound to the top level.
// ----------------------------------------------------------------------------
module xtea_chk
    import xtea_pkg::*;
#(
    parameter int CYCLE_COUNT = CYCLE_COUNT_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [2*WORD_W-1:0]  m_tdata
);

    localparam int BUSY_CYCLES = 2 * CYCLE_COUNT + 1;

    // ready drops as soon as a beat is taken and the block enters the rounds
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a block is in progress");

    // still busy on the output step after all rounds
    a_busy_full_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> ##BUSY_CYCLES !s_tready)
        else $error("sequencer left the rounds early");

    // a new result only appears right after the output step, never from idle
    a_result_from_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a finished run");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result beat changed");

endmodule

bind xtea_block_cipher_top xtea_chk #(.CYCLE_COUNT(CYCLE_COUNT)) u_xtea_chk (.*);
